### hw/rtl/safl_pkg.sv
`timescale 1ns / 1ps

package safl_pkg;

	// Fixed field widths
	localparam int SLOT_W     = 11;
	localparam int DATE_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;

	// Default sizes
	localparam int MAX_SLOTS_DEF  = 1024;
	localparam int FREE_DEPTH_DEF = 1024;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_DONE       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_IGNORED    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_LIST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_SPACE_FULL = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic              use_current;
		logic [DATE_W-1:0] current_date;
	} safl_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_out;
		logic [SLOT_W-1:0]   packed_pos;
		logic [STATUS_W-1:0] status;
	} safl_rsp_t;

	// One free-list entry: the freed slot and its stamp
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [DATE_W-1:0] date;
	} safl_entry_t;

endpackage

### hw/rtl/slot_allocator_aged_free_list.sv
`timescale 1ns / 1ps

// Slot allocator with an aged free list.
// Requests enter on in_valid/in_stall with in_req (cmd, slot, use_current,
// current_date); one response per request leaves on out_valid/out_stall with
// out_rsp (slot_out, packed_pos, status). The reuse interval is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce. Freed slots live in one
// synchronous circular memory (slot + date stamp, FREE_DEPTH entries,
// registered read). One request is in flight at a time; the next is taken
// once the current one has reached the output register, even while that
// response is still held by out_stall. Allocate, free and clear pass through
// accept, memory read (allocate only), evaluate/write back and output load,
// in that order. A query walks the free list one memory read per cycle
// through the single read port of the free-list memory.
// Reset clears the list head, count, high-water mark, current slot, the
// reuse interval and the output valid; the memory contents are left as they
// are, since only entries written by a free are ever read.
// While the receiver stalls, the response holds in the output register and
// a finished request waits before the output stage until it drains.
module slot_allocator_aged_free_list #(
	parameter int MAX_SLOTS  = safl_pkg::MAX_SLOTS_DEF,
	parameter int FREE_DEPTH = safl_pkg::FREE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [safl_pkg::INTERVAL_W-1:0]      cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  safl_pkg::safl_req_t                  in_req,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output safl_pkg::safl_rsp_t                  out_rsp
);

	localparam int HW_W   = $clog2(MAX_SLOTS + 1);
	localparam int SW     = (HW_W > safl_pkg::SLOT_W) ? HW_W : safl_pkg::SLOT_W;
	localparam int IDX_W  = $clog2(FREE_DEPTH);
	localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > safl_pkg::SLOT_W) ? CNT_W : safl_pkg::SLOT_W;
	localparam int DATE_W = safl_pkg::DATE_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	// Circular index: base + offset, folded once into the list depth
	function automatic logic [IDX_W-1:0] list_idx(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(FREE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(FREE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Control state
	logic [2:0]                      state_q;
	logic [IDX_W-1:0]                head_q;
	logic [CNT_W-1:0]                count_q;
	logic [SW-1:0]                   hw_q;
	logic [SW-1:0]                   cur_q;
	logic [safl_pkg::INTERVAL_W-1:0] interval_q;
	logic                            out_valid_q;
	logic [IDX_W-1:0]                walk_ptr_q;
	logic [CNT_W-1:0]                walk_rem_q;
	logic [CNT_W-1:0]                below_q;
	logic                            rd_vld_s1;

	// Payload registers
	safl_pkg::safl_req_t   req_q;
	safl_pkg::safl_rsp_t   res_q;
	safl_pkg::safl_rsp_t   out_q;
	safl_pkg::safl_entry_t rd_data_s1;

	// Free-list memory
	safl_pkg::safl_entry_t mem [FREE_DEPTH];

	logic                  in_acc;
	logic                  out_load;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	safl_pkg::safl_entry_t wr_data;

	logic [DATE_W:0]  due;
	logic             aged;
	logic             take_old;
	logic             take_new;
	logic             reuse;
	logic             grow_ok;
	logic [SW-1:0]    got;
	logic [safl_pkg::STATUS_W-1:0] alloc_sts;
	logic [SW-1:0]    free_s;
	logic             free_bad;
	logic             free_full;
	logic [safl_pkg::STATUS_W-1:0] free_sts;
	logic [CMP_W-1:0] below_ext;
	logic [CMP_W-1:0] qslot_ext;
	logic             walk_done;
	safl_pkg::safl_rsp_t eval_rsp;
	safl_pkg::safl_rsp_t walk_rsp;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		// Allocate: oldest entry once aged, newest entry for LIFO, else grow
		due       = {1'b0, rd_data_s1.date} + (DATE_W+1)'(interval_q);
		aged      = ({1'b0, req_q.current_date} >= due);
		take_old  = (count_q != '0) && (interval_q != '0) && aged;
		take_new  = (count_q != '0) && (interval_q == '0);
		reuse     = take_old || take_new;
		grow_ok   = (hw_q < SW'(MAX_SLOTS));
		got       = reuse ? SW'(rd_data_s1.slot) : (hw_q + SW'(1));
		alloc_sts = (!reuse && !grow_ok) ? safl_pkg::STS_SPACE_FULL : safl_pkg::STS_DONE;

		// Free: validate slot, then append at the tail
		free_s    = req_q.use_current ? cur_q : SW'(req_q.slot);
		free_bad  = (free_s == '0) || (free_s > hw_q);
		free_full = (count_q == CNT_W'(FREE_DEPTH));
		priority if (free_bad) begin
			free_sts = safl_pkg::STS_IGNORED;
		end else if (free_full) begin
			free_sts = safl_pkg::STS_LIST_FULL;
		end else begin
			free_sts = safl_pkg::STS_DONE;
		end

		wr_en        = (state_q == S_EVAL) && (req_q.cmd == safl_pkg::CMD_FREE) &&
			!free_bad && !free_full;
		wr_addr      = list_idx(head_q, count_q);
		wr_data.slot = free_s[safl_pkg::SLOT_W-1:0];
		wr_data.date = req_q.current_date;

		// Read port: head or tail entry for allocate, walk pointer for query
		if (state_q == S_WALK) begin
			rd_en   = (walk_rem_q != '0);
			rd_addr = walk_ptr_q;
		end else begin
			rd_en   = (state_q == S_ISSUE) && (req_q.cmd == safl_pkg::CMD_ALLOC) &&
				(count_q != '0);
			rd_addr = (interval_q != '0) ? head_q : list_idx(head_q, count_q - CNT_W'(1));
		end

		eval_rsp = '0;
		unique case (req_q.cmd)
			safl_pkg::CMD_ALLOC: begin
				eval_rsp.status = alloc_sts;
				if (alloc_sts == safl_pkg::STS_DONE) begin
					eval_rsp.slot_out = got[safl_pkg::SLOT_W-1:0];
				end
			end
			safl_pkg::CMD_FREE:  eval_rsp.status = free_sts;
			safl_pkg::CMD_QUERY: eval_rsp.status = safl_pkg::STS_DONE;
			safl_pkg::CMD_CLEAR: eval_rsp.status = safl_pkg::STS_DONE;
			default:             eval_rsp.status = safl_pkg::STS_DONE;
		endcase

		// Query: packed position, saturated at zero
		below_ext = CMP_W'(below_q);
		qslot_ext = CMP_W'(req_q.slot);
		walk_done = (walk_rem_q == '0) && !rd_vld_s1;
		walk_rsp  = '0;
		walk_rsp.status = safl_pkg::STS_DONE;
		if (below_ext < qslot_ext) begin
			walk_rsp.packed_pos = safl_pkg::SLOT_W'(qslot_ext - below_ext);
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_req;
		end
		if (state_q == S_EVAL) begin
			res_q <= eval_rsp;
		end else if ((state_q == S_WALK) && walk_done) begin
			res_q <= walk_rsp;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Control and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			hw_q        <= '0;
			cur_q       <= '0;
			interval_q  <= '0;
			out_valid_q <= 1'b0;
			walk_ptr_q  <= '0;
			walk_rem_q  <= '0;
			below_q     <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interval_q <= cfg_wr_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= (state_q == S_WALK) && rd_en;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_req.cmd == safl_pkg::CMD_QUERY) begin
							walk_ptr_q <= head_q;
							walk_rem_q <= count_q;
							below_q    <= '0;
							state_q    <= S_WALK;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: state_q <= S_EVAL;
				S_EVAL: begin
					unique case (req_q.cmd)
						safl_pkg::CMD_ALLOC: begin
							if (take_old) begin
								head_q <= list_idx(head_q, CNT_W'(1));
							end
							if (reuse) begin
								count_q <= count_q - CNT_W'(1);
							end else if (grow_ok) begin
								hw_q <= hw_q + SW'(1);
							end
							if (alloc_sts == safl_pkg::STS_DONE) begin
								cur_q <= got;
							end
						end
						safl_pkg::CMD_FREE: begin
							if (wr_en) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						safl_pkg::CMD_CLEAR: begin
							head_q  <= '0;
							count_q <= '0;
							hw_q    <= '0;
							cur_q   <= '0;
						end
						default: ;
					endcase
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (rd_en) begin
						walk_ptr_q <= list_idx(walk_ptr_q, CNT_W'(1));
						walk_rem_q <= walk_rem_q - CNT_W'(1);
					end
					if (rd_vld_s1 && (rd_data_s1.slot < req_q.slot)) begin
						below_q <= below_q + CNT_W'(1);
					end
					if (walk_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The list never holds more entries than the memory has
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FREE_DEPTH))
		else $error("free list count exceeds depth");

	// The mark never passes the record space
	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= SW'(MAX_SLOTS))
		else $error("high-water mark exceeds record space");

	// Memory writes come only from an accepted free in its evaluate step
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_EVAL) && (req_q.cmd == safl_pkg::CMD_FREE) &&
			(count_q < CNT_W'(FREE_DEPTH)))
		else $error("free-list write outside a valid free");

	// A walk read result is only consumed during the walk that issued it
	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_WALK))
		else $error("walk read returned outside the walk");

	// A new response enters the output only from the finish step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && (!out_valid_q || !out_stall) |=> out_valid_q &&
			(state_q == S_IDLE))
		else $error("response not loaded on finish");

endmodule
